FILE: hw/rtl/xsrb_pkg.sv
// ----------------------------------------------------------------------------
// xsrb_pkg: shared types and constants for the sprite row blitter
// Word layouts of the draw/read channel, operation and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package xsrb_pkg;

  localparam int HALF_W = 64;   // pixels in one stored half-line
  localparam int COL_W  = 7;    // column index, screen width at most 128
  localparam int LANES  = 16;   // one lane per pixel of a wide row

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_HIRES = 1'b0;
  localparam logic REG_WRAP  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [3:0]  row_offset;
    logic        wide;
    logic [15:0] row_bits;
    logic        first_row;
    logic [5:0]  read_line;
    logic        read_half;
  } req_t;

  typedef struct packed {
    logic        collision;
    logic [63:0] line_data;
  } rsp_t;

  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
  } lane_hit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xsrb_pixel_lane.sv
// ----------------------------------------------------------------------------
// xsrb_pixel_lane: one pixel of a sprite row
// Picks the lane's pixel from the row and places it on a screen column,
// wrapping or clipping at the right edge.
// ----------------------------------------------------------------------------
`default_nettype none

module xsrb_pixel_lane
  import xsrb_pkg::*;
(
  input  wire logic [3:0]       lane,
  input  wire logic [COL_W-1:0] x0,
  input  wire logic [15:0]      row_bits,
  input  wire logic             wide,
  input  wire logic             wrap,
  input  wire logic [7:0]       width,
  output lane_hit_t             result
);

  logic       pix;
  logic [7:0] sum;
  logic [7:0] col;
  logic       keep;

  always_comb begin
    // Narrow rows sit in the low byte; lanes 8..15 carry nothing then.
    if (wide) begin
      pix = row_bits[4'd15 - lane];
    end else begin
      pix = !lane[3] && row_bits[{1'b0, 3'd7 - lane[2:0]}];
    end
    sum  = {1'b0, x0} + {4'b0000, lane};
    col  = sum;
    keep = 1'b1;
    if (sum >= width) begin
      if (wrap) begin
        col = sum - width;
      end else begin
        keep = 1'b0;
      end
    end
    result.hit = pix && keep;
    result.col = col[COL_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xsrb_row_merge.sv
// ----------------------------------------------------------------------------
// xsrb_row_merge: merge lane columns into half-line masks
// Each lit lane sets one bit in the mask of the half that holds its column.
// ----------------------------------------------------------------------------
`default_nettype none

module xsrb_row_merge
  import xsrb_pkg::*;
(
  input  wire lane_hit_t           lanes [LANES],
  output logic      [HALF_W-1:0]   mask_lo,
  output logic      [HALF_W-1:0]   mask_hi
);

  always_comb begin
    mask_lo = '0;
    mask_hi = '0;
    for (int i = 0; i < LANES; i++) begin
      // Bit 63 is the leftmost column of a half.
      if (lanes[i].hit && !lanes[i].col[6]) begin
        mask_lo[6'd63 - lanes[i].col[5:0]] = 1'b1;
      end
      if (lanes[i].hit && lanes[i].col[6]) begin
        mask_hi[6'd63 - lanes[i].col[5:0]] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xsrb_half_bank.sv
// ----------------------------------------------------------------------------
// xsrb_half_bank: storage for one 64-pixel half of every line
// One read and one write port, registered read, per-line valid bits so that
// lines never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module xsrb_half_bank
  import xsrb_pkg::*;
#(
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [HALF_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [HALF_W-1:0] wr_data
);

  logic [HALF_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  line_valid;
  logic [HALF_W-1:0] rd_word;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        line_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= line_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/xor_sprite_row_blitter_core.sv
// ----------------------------------------------------------------------------
// xor_sprite_row_blitter_core: one-bit framebuffer with XOR sprite rows
// Keeps a 64x32 or MAX_WIDTH x MAX_HEIGHT monochrome screen and XORs sprite
// rows of 8 or 16 pixels into it, tracking collisions.
//
// Usage:
//   The req channel (req_valid / req_stall / req) carries one word per item:
//   a draw of one sprite row or a read of one 64-pixel half-line. Every item
//   gives exactly one word on the rsp channel (rsp_valid / rsp_stall / rsp)
//   with the collision flag after the item and, on a read, the pixels.
//   The cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
//   screen size and the wrap mode; it is always ready. The user must write it only
//   while no item is in flight; the block itself does not enforce this.
//   An item has a read step and a write-back step: the line is read from both
//   half banks in the cycle after acceptance and written back once the output
//   register is free; the next item is accepted in that write-back cycle and
//   the result word is registered there; the read-modify-write paces items.
//   When rsp_stall holds a finished result in the output register, the next
//   item is taken and waits in its write-back step until the register frees.
//   A synchronous reset clears the configuration, the collision flag and the
//   line valid bits, so the whole screen reads as zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_sprite_row_blitter_core
  import xsrb_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_index,
  input  wire logic cfg_data
);

  localparam int AW = $clog2(MAX_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state, state_next;
  req_t   cur;
  logic   hires;
  logic   wrap_sprite;
  logic   collision_flag;
  logic   collision_flag_next;
  logic   out_free;
  logic   req_take;

  // Screen geometry.
  logic [7:0] scr_w;
  logic [6:0] scr_h;

  // Origin reduction and line computation.
  logic [8:0] x_rem;
  logic [9:0] y_rem;
  logic [6:0] line_calc;
  logic       draw_ok;
  logic       read_ok;

  lane_hit_t         lanes [LANES];
  logic [HALF_W-1:0] mask_lo_c;
  logic [HALF_W-1:0] mask_hi_c;

  // Registered between the read and write-back steps.
  logic [HALF_W-1:0] mask_lo;
  logic [HALF_W-1:0] mask_hi;
  logic [AW-1:0]     line;
  logic              draw_q;
  logic              read_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [HALF_W-1:0] old_lo;
  logic [HALF_W-1:0] old_hi;
  logic              erased;

  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == S_IDLE || (state == S_WRITE && out_free));
  assign req_take  = req_valid && !req_stall;

  assign scr_w = hires ? 8'(MAX_WIDTH) : 8'd64;
  assign scr_h = hires ? 7'(MAX_HEIGHT) : 7'd32;

  always_ff @(posedge clk) begin
    if (rst) begin
      hires       <= 1'b0;
      wrap_sprite <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIRES: hires       <= cfg_data;
        REG_WRAP:  wrap_sprite <= cfg_data;
        default:   ;
      endcase
    end
  end

  // The width is at least 64, so pos_x holds at most three widths.
  always_comb begin
    x_rem = {1'b0, cur.pos_x};
    if (x_rem >= {scr_w, 1'b0}) begin
      x_rem = x_rem - {scr_w, 1'b0};
    end
    if (x_rem >= {1'b0, scr_w}) begin
      x_rem = x_rem - {1'b0, scr_w};
    end
  end

  // The height is at least 32, so pos_y holds at most seven heights.
  always_comb begin
    y_rem = {2'b00, cur.pos_y};
    if (y_rem >= {1'b0, scr_h, 2'b00}) begin
      y_rem = y_rem - {1'b0, scr_h, 2'b00};
    end
    if (y_rem >= {2'b00, scr_h, 1'b0}) begin
      y_rem = y_rem - {2'b00, scr_h, 1'b0};
    end
    if (y_rem >= {3'b000, scr_h}) begin
      y_rem = y_rem - {3'b000, scr_h};
    end
  end

  always_comb begin
    line_calc = {1'b0, y_rem[5:0]} + {3'b000, cur.row_offset};
    draw_ok   = 1'b1;
    if (line_calc >= scr_h) begin
      if (wrap_sprite) begin
        line_calc = line_calc - scr_h;
      end else begin
        draw_ok = 1'b0;
      end
    end
  end

  assign read_ok = {1'b0, cur.read_line} < 7'(MAX_HEIGHT);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    xsrb_pixel_lane u_lane (
      .lane     (4'(g)),
      .x0       (x_rem[COL_W-1:0]),
      .row_bits (cur.row_bits),
      .wide     (cur.wide),
      .wrap     (wrap_sprite),
      .width    (scr_w),
      .result   (lanes[g])
    );
  end

  xsrb_row_merge u_merge (
    .lanes   (lanes),
    .mask_lo (mask_lo_c),
    .mask_hi (mask_hi_c)
  );

  always_comb begin
    if (cur.operation == OP_DRAW) begin
      rd_en   = (state == S_CALC) && draw_ok;
      rd_addr = line_calc[AW-1:0];
    end else begin
      rd_en   = (state == S_CALC) && read_ok;
      rd_addr = cur.read_line[AW-1:0];
    end
  end

  assign wr_en = (state == S_WRITE) && out_free && (cur.operation == OP_DRAW) && draw_q;

  xsrb_half_bank #(.DEPTH(MAX_HEIGHT)) u_bank_lo (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (old_lo),
    .wr_en   (wr_en),
    .wr_addr (line),
    .wr_data (old_lo ^ mask_lo)
  );

  xsrb_half_bank #(.DEPTH(MAX_HEIGHT)) u_bank_hi (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (old_hi),
    .wr_en   (wr_en),
    .wr_addr (line),
    .wr_data (old_hi ^ mask_hi)
  );

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur <= req;
    end
    if (state == S_CALC) begin
      mask_lo <= mask_lo_c;
      mask_hi <= mask_hi_c;
      line    <= line_calc[AW-1:0];
      draw_q  <= draw_ok;
      read_q  <= read_ok;
    end
  end

  // A collision is any lit pixel under a set mask bit.
  assign erased = draw_q && (|(old_lo & mask_lo) || |(old_hi & mask_hi));

  always_comb begin
    collision_flag_next = collision_flag;
    if (cur.operation == OP_DRAW) begin
      collision_flag_next = (collision_flag && !cur.first_row) || erased;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          state_next = req_take ? S_CALC : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      collision_flag <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_WRITE && out_free) begin
        collision_flag <= collision_flag_next;
        rsp_valid      <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE && out_free) begin
      rsp.collision <= collision_flag_next;
      if (cur.operation == OP_READ && read_q) begin
        rsp.line_data <= cur.read_half ? old_hi : old_lo;
      end else begin
        rsp.line_data <= '0;
      end
    end
  end

  a_take_state: assert property (@(posedge clk) disable iff (rst)
    req_take |-> (state == S_IDLE || state == S_WRITE))
    else $error("item accepted while another is being worked on");

  a_write_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_WRITE && !rd_en))
    else $error("line written outside the write-back step");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && out_free) |=> rsp_valid)
    else $error("finished item left no result word");

  a_flag_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(collision_flag) |-> $past(state == S_WRITE && cur.operation == OP_DRAW))
    else $error("collision flag set without a draw");

  a_calc_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |=> (state == S_WRITE))
    else $error("read step not followed by write-back");

endmodule

`default_nettype wire
